@@ src/rmth_pkg.sv @@
// ---------------------------------------------------------------------------
// rmth_pkg
// shared types and defaults for the running median block
// ---------------------------------------------------------------------------
`default_nettype none

package rmth_pkg;

	// default configuration of the top level
	localparam int DEF_CAPACITY     = 1024;
	localparam int DEF_SAMPLE_WIDTH = 32;

	// fixed width of the reported sample count
	localparam int HELD_COUNT_W = 11;

	// operation applied to every cell of a half chain at once
	typedef enum logic [2:0] {
		CELL_HOLD   = 3'd0,
		CELL_CLEAR  = 3'd1,
		CELL_PUSH   = 3'd2,
		CELL_POP    = 3'd3,
		CELL_INSERT = 3'd4
	} cell_op_t;

endpackage

`default_nettype wire

@@ src/rmth_cell.sv @@
// ---------------------------------------------------------------------------
// rmth_cell
// one slot of a sorted half chain: value, occupancy, neighbor hand-off
// ---------------------------------------------------------------------------
`default_nettype none

module rmth_cell #(
	parameter int SAMPLE_WIDTH = rmth_pkg::DEF_SAMPLE_WIDTH,
	parameter bit DESCEND      = 1'b1
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  rmth_pkg::cell_op_t            op,
	input  wire signed [SAMPLE_WIDTH-1:0] din,
	input  wire signed [SAMPLE_WIDTH-1:0] prev_val,
	input  wire                           prev_ahead,
	input  wire                           prev_occ,
	input  wire signed [SAMPLE_WIDTH-1:0] next_val,
	input  wire                           next_occ,
	output logic signed [SAMPLE_WIDTH-1:0] val,
	output logic                          ahead,
	output logic                          occ
);
	import rmth_pkg::*;

	logic signed [SAMPLE_WIDTH-1:0] val_q;
	logic                           occ_q;

	// this entry stays in front of an inserted value
	always_comb begin
		if (DESCEND) begin
			ahead = occ_q && (val_q > din);
		end else begin
			ahead = occ_q && (val_q < din);
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			CELL_PUSH: begin
				val_q <= prev_val;
			end
			CELL_POP: begin
				val_q <= next_val;
			end
			CELL_INSERT: begin
				if (!ahead) begin
					val_q <= prev_ahead ? din : prev_val;
				end
			end
			default: begin
				val_q <= val_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else begin
			case (op)
				CELL_CLEAR:  occ_q <= 1'b0;
				CELL_PUSH:   occ_q <= prev_occ;
				CELL_POP:    occ_q <= next_occ;
				CELL_INSERT: occ_q <= occ_q | prev_occ;
				default:     occ_q <= occ_q;
			endcase
		end
	end

	assign val = val_q;
	assign occ = occ_q;

endmodule

`default_nettype wire

@@ src/rmth_chain.sv @@
// ---------------------------------------------------------------------------
// rmth_chain
// one half of the store as a row of sorted cells, extreme value at the head
// ---------------------------------------------------------------------------
`default_nettype none

module rmth_chain #(
	parameter int DEPTH        = rmth_pkg::DEF_CAPACITY / 2,
	parameter int SAMPLE_WIDTH = rmth_pkg::DEF_SAMPLE_WIDTH,
	parameter bit DESCEND      = 1'b1
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  rmth_pkg::cell_op_t            op,
	input  wire signed [SAMPLE_WIDTH-1:0] din,
	output logic signed [SAMPLE_WIDTH-1:0] head
);
	import rmth_pkg::*;

	logic signed [SAMPLE_WIDTH-1:0] val   [DEPTH];
	logic                           ahead [DEPTH];
	logic                           occ   [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [SAMPLE_WIDTH-1:0] p_val;
		logic                           p_ahead;
		logic                           p_occ;
		logic signed [SAMPLE_WIDTH-1:0] n_val;
		logic                           n_occ;

		// head cell sees the incoming value as its front neighbor
		if (i == 0) begin : g_first
			assign p_val   = din;
			assign p_ahead = 1'b1;
			assign p_occ   = 1'b1;
		end else begin : g_inner
			assign p_val   = val[i-1];
			assign p_ahead = ahead[i-1];
			assign p_occ   = occ[i-1];
		end

		// tail cell pulls an empty slot on a pop
		if (i == DEPTH - 1) begin : g_last
			assign n_val = val[i];
			assign n_occ = 1'b0;
		end else begin : g_body
			assign n_val = val[i+1];
			assign n_occ = occ[i+1];
		end

		rmth_cell #(
			.SAMPLE_WIDTH (SAMPLE_WIDTH),
			.DESCEND      (DESCEND)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.op         (op),
			.din        (din),
			.prev_val   (p_val),
			.prev_ahead (p_ahead),
			.prev_occ   (p_occ),
			.next_val   (n_val),
			.next_occ   (n_occ),
			.val        (val[i]),
			.ahead      (ahead[i]),
			.occ        (occ[i])
		);
	end

	assign head = val[0];

endmodule

`default_nettype wire

@@ src/running_median_two_heaps.sv @@
// ---------------------------------------------------------------------------
// running_median_two_heaps
// running median of a signed sample stream over two sorted cell chains
// ---------------------------------------------------------------------------
//
//  channel | handshake          | payload
//  --------+--------------------+------------------------------------------
//  in      | in_valid/in_stall  | sample, start_new
//  out     | out_valid/out_stall| median_x2, held_count, dropped
//
//  each transaction runs accept, rebalance, insert, median in turn;
//  rebalance and insert pass over the cell chains, and median is the add
//  a dropped sample skips the insert step
//  reset empties both chains at once through the cell occupancy flops
//  in_stall is high from accept until the result is loaded; a stalled
//  result waits in the output register and holds only the median step
//
`default_nettype none

module running_median_two_heaps #(
	parameter int CAPACITY     = rmth_pkg::DEF_CAPACITY,
	parameter int SAMPLE_WIDTH = rmth_pkg::DEF_SAMPLE_WIDTH
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  in_valid,
	output logic                                 in_stall,
	input  wire signed [SAMPLE_WIDTH-1:0]        sample,
	input  wire                                  start_new,
	output logic                                 out_valid,
	input  wire                                  out_stall,
	output logic signed [SAMPLE_WIDTH:0]         median_x2,
	output logic [rmth_pkg::HELD_COUNT_W-1:0]    held_count,
	output logic                                 dropped
);
	import rmth_pkg::*;

	// each half holds at most half the capacity, rounded up
	localparam int HALF   = (CAPACITY + 1) / 2;
	localparam int SZ_W   = $clog2(HALF + 1);
	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int WIDE_W = (CNT_W > HELD_COUNT_W) ? CNT_W : HELD_COUNT_W;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MOVE = 4'b0010,
		ST_INS  = 4'b0100,
		ST_MED  = 4'b1000
	} state_t;

	state_t state_q;

	// latched input transaction
	logic signed [SAMPLE_WIDTH-1:0] key_q;
	logic                           start_q;
	logic                           below_q;
	logic                           drop_q;

	// occupancy of each half
	logic [SZ_W-1:0] lsize_q;
	logic [SZ_W-1:0] usize_q;

	// output register
	logic                        out_valid_q;
	logic signed [SAMPLE_WIDTH:0] median_q;
	logic [HELD_COUNT_W-1:0]     held_q;
	logic                        dropped_q;

	// chain control
	cell_op_t                       lower_op;
	cell_op_t                       upper_op;
	logic signed [SAMPLE_WIDTH-1:0] lower_din;
	logic signed [SAMPLE_WIDTH-1:0] upper_din;
	logic signed [SAMPLE_WIDTH-1:0] lower_head;
	logic signed [SAMPLE_WIDTH-1:0] upper_head;

	logic                         in_fire;
	logic                         out_free;
	logic signed [SAMPLE_WIDTH:0] pair_sum;
	logic signed [SAMPLE_WIDTH:0] two_key;
	logic [SZ_W-1:0]              lsize_e;
	logic [SZ_W-1:0]              usize_e;
	logic [CNT_W-1:0]             total;
	logic [WIDE_W-1:0]            total_w;
	logic                         full;
	logic                         below;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_fire   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;

	// twice the median of the current heads, 0 when both halves are empty
	always_comb begin
		if (lsize_q == usize_q && lsize_q != '0) begin
			pair_sum = $signed({lower_head[SAMPLE_WIDTH-1], lower_head})
				+ $signed({upper_head[SAMPLE_WIDTH-1], upper_head});
		end else if (usize_q > lsize_q) begin
			pair_sum = $signed({upper_head, 1'b0});
		end else if (lsize_q != '0) begin
			pair_sum = $signed({lower_head, 1'b0});
		end else begin
			pair_sum = '0;
		end
	end

	// sizes as seen after an optional restart
	assign lsize_e = start_q ? '0 : lsize_q;
	assign usize_e = start_q ? '0 : usize_q;
	assign total   = CNT_W'(lsize_e) + CNT_W'(usize_e);
	assign full    = (total >= CNT_W'(CAPACITY));
	assign two_key = $signed({key_q, 1'b0});

	// route below the median; an empty store compares against zero
	assign below = (lsize_e == '0 && usize_e == '0) ? key_q[SAMPLE_WIDTH-1]
		: (two_key < pair_sum);

	// count after this transaction, at least as wide as the reported count
	assign total_w = WIDE_W'(CNT_W'(lsize_q) + CNT_W'(usize_q));

	// per-state chain operations
	always_comb begin
		lower_op  = CELL_HOLD;
		upper_op  = CELL_HOLD;
		lower_din = key_q;
		upper_din = key_q;
		case (state_q)
			ST_MOVE: begin
				if (start_q) begin
					lower_op = CELL_CLEAR;
					upper_op = CELL_CLEAR;
				end else if (!full) begin
					// keep the halves within one of each other
					if (below && lsize_q > usize_q) begin
						lower_op  = CELL_POP;
						upper_op  = CELL_PUSH;
						upper_din = lower_head;
					end else if (!below && usize_q > lsize_q) begin
						upper_op  = CELL_POP;
						lower_op  = CELL_PUSH;
						lower_din = upper_head;
					end
				end
			end
			ST_INS: begin
				if (below_q) begin
					lower_op = CELL_INSERT;
				end else begin
					upper_op = CELL_INSERT;
				end
			end
			default: begin
				lower_op = CELL_HOLD;
				upper_op = CELL_HOLD;
			end
		endcase
	end

	// lower half: max at the head
	rmth_chain #(
		.DEPTH        (HALF),
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.DESCEND      (1'b1)
	) u_lower (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (lower_op),
		.din    (lower_din),
		.head   (lower_head)
	);

	// upper half: min at the head
	rmth_chain #(
		.DEPTH        (HALF),
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.DESCEND      (1'b0)
	) u_upper (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (upper_op),
		.din    (upper_din),
		.head   (upper_head)
	);

	// latched transaction fields
	always_ff @(posedge clk) begin
		if (in_fire) begin
			key_q   <= sample;
			start_q <= start_new;
		end
		if (state_q == ST_MOVE) begin
			below_q <= below;
			drop_q  <= full;
		end
	end

	// sequencer and half sizes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			lsize_q <= '0;
			usize_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_MOVE;
					end
				end
				ST_MOVE: begin
					if (start_q) begin
						lsize_q <= '0;
						usize_q <= '0;
						state_q <= ST_INS;
					end else if (full) begin
						// full store: skip straight to the result
						state_q <= ST_MED;
					end else begin
						if (below && lsize_q > usize_q) begin
							lsize_q <= lsize_q - 1'b1;
							usize_q <= usize_q + 1'b1;
						end else if (!below && usize_q > lsize_q) begin
							usize_q <= usize_q - 1'b1;
							lsize_q <= lsize_q + 1'b1;
						end
						state_q <= ST_INS;
					end
				end
				ST_INS: begin
					if (below_q) begin
						lsize_q <= lsize_q + 1'b1;
					end else begin
						usize_q <= usize_q + 1'b1;
					end
					state_q <= ST_MED;
				end
				ST_MED: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output register; median_q also keeps the last median for dropped samples
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			median_q    <= '0;
			held_q      <= '0;
			dropped_q   <= 1'b0;
		end else begin
			if (state_q == ST_MED && out_free) begin
				out_valid_q <= 1'b1;
				held_q      <= total_w[HELD_COUNT_W-1:0];
				dropped_q   <= drop_q;
				if (!drop_q) begin
					median_q <= pair_sum;
				end
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign median_x2  = median_q;
	assign held_count = held_q;
	assign dropped    = dropped_q;

endmodule

`default_nettype wire
